FILE: hw/rtl/spdf_pkg.sv
// spdf_pkg: types and constants shared by the small prime divisibility filter
// no dependencies; imported by spdf_recip, spdf_cell, spdf_checker and the top level
`default_nettype none

package spdf_pkg;

  localparam int unsigned SlotW       = 16;  // width of one divisor slot
  localparam int unsigned NumW        = 32;  // width of a candidate that can survive
  localparam int unsigned CandW       = 64;  // width of the incoming candidate
  localparam int unsigned CfgRegs     = 4;   // configuration registers
  localparam int unsigned CfgIdxW     = 2;   // register index width
  localparam int unsigned CfgW        = 64;  // configuration data width
  localparam int unsigned SlotsPerReg = 4;   // divisor slots per register
  localparam int unsigned RecipSteps  = 32;  // quotient bits of 2^32 / p
  localparam int unsigned RecipCntW   = 6;   // counter wide enough for RecipSteps
  localparam int unsigned RemW        = 17;  // barrett remainder before correction
  localparam int unsigned OutTdataW   = 8;   // result tdata width

  // word handed from cell to cell
  typedef struct packed {
    logic [NumW-1:0] num;    // low 32 bits of the candidate
    logic            alive;  // fits in 32 bits and no divisor rejected it so far
    logic            last;   // end of stream marker
  } spdf_word_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spdf_recip.sv
// spdf_recip: bit-serial restoring divider that forms floor(2^32 / p)
// one quotient bit per cycle; uses spdf_pkg
`default_nettype none

module spdf_recip (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [spdf_pkg::SlotW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [spdf_pkg::NumW-1:0]  recip_o
);
  import spdf_pkg::*;

  logic [SlotW-1:0]     rem_q, rem_d;
  logic [NumW-1:0]      quo_q, quo_d;
  logic [RecipCntW-1:0] cnt_q, cnt_d;
  logic [SlotW:0]       trial;
  logic                 fits;

  assign trial = {rem_q, 1'b0};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      // the leading one of 2^32 is already shifted in; it is below any p >= 2
      rem_d = SlotW'(1);
      quo_d = '0;
      cnt_d = RecipCntW'(RecipSteps);
    end else if (cnt_q != '0) begin
      if (fits) begin
        rem_d = SlotW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[SlotW-1:0];
      end
      quo_d = {quo_q[NumW-2:0], fits};
      cnt_d = cnt_q - RecipCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o  = cnt_q != '0;
  assign recip_o = quo_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spdf_cell.sv
// spdf_cell: one divisor slot of the filter chain, three stages of barrett reduction
// holds its divisor and reciprocal; uses spdf_pkg and spdf_recip
`default_nettype none

module spdf_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [spdf_pkg::SlotW-1:0] cfg_data_i,
  output logic                       busy_o,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  spdf_pkg::spdf_word_t       in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output spdf_pkg::spdf_word_t       out_word_o
);
  import spdf_pkg::*;

  logic [SlotW-1:0] div_q;
  logic [NumW-1:0]  recip;

  logic             v1_q, v2_q, v3_q;
  logic             rdy1, rdy2, rdy3;
  spdf_word_t       w1_q, w2_q, w3_q, w3_d;
  logic [NumW-1:0]  quot_q;
  logic [RemW-1:0]  rem_q;

  logic [2*NumW-1:0]    prod;
  logic [NumW+SlotW-1:0] qp;
  logic [NumW-1:0]      diff;
  logic                 rejected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q <= '0;
    end else if (cfg_we_i) begin
      div_q <= cfg_data_i;
    end
  end

  spdf_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we_i),
    .divisor_i (div_q),
    .busy_o    (busy_o),
    .recip_o   (recip)
  );

  // a stage takes a new word when empty or when its word moves on
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // stage 1: estimated quotient (n * m) >> 32
  assign prod = in_word_i.num * recip;

  // stage 2: n - q*p, below 2p
  assign qp   = quot_q * div_q;
  assign diff = w1_q.num - qp[NumW-1:0];

  // stage 3: correction folded into the zero test; divisor one always divides
  always_comb begin
    rejected = (div_q != '0) && (w2_q.num != NumW'(div_q)) &&
               ((div_q == SlotW'(1)) || (rem_q == '0) || (rem_q == RemW'(div_q)));
    w3_d       = w2_q;
    w3_d.alive = w2_q.alive && !rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      w1_q   <= in_word_i;
      quot_q <= prod[2*NumW-1:NumW];
    end
    if (rdy2) begin
      w2_q  <= w1_q;
      rem_q <= diff[RemW-1:0];
    end
    if (rdy3) begin
      w3_q <= w3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_word_o  = w3_q;

endmodule

`default_nettype wire

FILE: hw/rtl/small_prime_divisibility_filter_core.sv
// throughput one word per cycle while the output is ready and no cell forms its reciprocal
// the chain stalls stage by stage, so bubbles close up while a result waits at the output
// each cell forms its reciprocal bit-serially: after a config write input is held off meanwhile
// reset (rst_ni low, asynchronous) empties the chain and clears all divisors to disabled
// small_prime_divisibility_filter_core: chain of spdf_cell, one per divisor slot
// uses spdf_pkg, spdf_cell
`default_nettype none

module small_prime_divisibility_filter_core #(
  parameter int unsigned NUM_DIVISORS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spdf_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [spdf_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [spdf_pkg::CandW-1:0]   s_axis_tdata_i,  // [63:0] candidate
  input  logic                         s_axis_tlast_i,  // last_in
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [spdf_pkg::OutTdataW-1:0] m_axis_tdata_o, // [0] survives, [7:1] zero
  output logic                         m_axis_tlast_o   // last_out
);
  import spdf_pkg::*;

  logic             valid [NUM_DIVISORS+1];
  logic             ready [NUM_DIVISORS+1];
  spdf_word_t       word  [NUM_DIVISORS+1];
  logic [NUM_DIVISORS-1:0] busy;

  assign valid[0]           = s_axis_tvalid_i && !(|busy);
  assign s_axis_tready_o    = ready[0] && !(|busy);
  assign word[0].num        = s_axis_tdata_i[NumW-1:0];
  assign word[0].alive      = s_axis_tdata_i[CandW-1:NumW] == '0;
  assign word[0].last       = s_axis_tlast_i;

  for (genvar k = 0; k < NUM_DIVISORS; k++) begin : g_cell
    localparam int unsigned RegIdx = k / SlotsPerReg;
    localparam int unsigned SubIdx = k % SlotsPerReg;

    spdf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_we_i    (cfg_we_i && (cfg_addr_i == CfgIdxW'(RegIdx))),
      .cfg_data_i  (cfg_wdata_i[SlotW*SubIdx +: SlotW]),
      .busy_o      (busy[k]),
      .in_valid_i  (valid[k]),
      .in_ready_o  (ready[k]),
      .in_word_i   (word[k]),
      .out_valid_o (valid[k+1]),
      .out_ready_i (ready[k+1]),
      .out_word_o  (word[k+1])
    );
  end

  assign ready[NUM_DIVISORS] = m_axis_tready_i;
  assign m_axis_tvalid_o     = valid[NUM_DIVISORS];
  assign m_axis_tdata_o      = {(OutTdataW-1)'(0), word[NUM_DIVISORS].alive};
  assign m_axis_tlast_o      = word[NUM_DIVISORS].last;

endmodule

`default_nettype wire

FILE: hw/rtl/spdf_checker.sv
// spdf_checker: port-level assertions for small_prime_divisibility_filter_core
// bound to the top level below; uses spdf_pkg
`default_nettype none

module spdf_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spdf_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic                         s_axis_tvalid_i,
  input  logic                         s_axis_tready_o,
  input  logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i
);
  import spdf_pkg::*;

  logic [7:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  // slot zero always exists, so a write to register zero starts a reciprocal pass
  a_cfg_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_addr_i == '0)) |=> !s_axis_tready_o)
    else $error("input taken while reciprocals are being formed");

  // no result word without an accepted input word behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pending_q != '0))
    else $error("result word with no pending input word");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result word dropped before it was taken");

endmodule

bind small_prime_divisibility_filter_core spdf_checker u_spdf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_addr_i      (cfg_addr_i),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire
